### hw/rtl/tccw_pkg.sv
// Shared types and constants of the text console cell writer.
// Used by the front, queue, back and top-level files; depends on nothing.
package tccw_pkg;

    // Opcodes of an input transaction
    localparam logic [2:0] OPC_STR_CHAR = 3'd0;
    localparam logic [2:0] OPC_STR_END  = 3'd1;
    localparam logic [2:0] OPC_PUT_CHAR = 3'd2;
    localparam logic [2:0] OPC_BACK     = 3'd3;
    localparam logic [2:0] OPC_SET_CUR  = 3'd4;

    // Character codes with special meaning inside strings
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Screen size and system-mode cursor limit
    localparam int unsigned SCREEN_CELLS = 2000;
    localparam int unsigned SYS_LIMIT    = 2000;

    // Result kinds
    localparam logic RK_CELL   = 1'b0;
    localparam logic RK_CURSOR = 1'b1;

    // Register index of the mode register
    localparam int unsigned REG_SYSTEM_MODE = 0;

    // Column field in the queue: wide enough for screens up to 256 columns
    localparam int unsigned COL_BITS = 8;

    // Queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Classified operation
    typedef enum logic [3:0] {
        OPK_NOP,
        OPK_CHAR,
        OPK_NEWLINE,
        OPK_RETURN,
        OPK_TAB,
        OPK_END,
        OPK_PUT,
        OPK_BACK,
        OPK_SET
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [7:0]            char_code;
        logic [7:0]            color;
        logic                  auto_newline;
        logic [15:0]           position;
        logic [COL_BITS-1:0]   pos_col;
    } t_op_entry;

    typedef struct packed {
        logic        kind;
        logic [15:0] cell_index;
        logic [7:0]  char_out;
        logic [7:0]  attr_out;
        logic        in_screen;
        logic        last;
    } t_result;

endpackage

### hw/rtl/tccw_front.sv
// Front stage: accepts input transactions, classifies them and works out
// the column of a requested cursor position. Depends on tccw_pkg.
module tccw_front #(
    parameter int unsigned SCREEN_WIDTH = 80
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_opcode,
    input  logic [7:0]           i_char_code,
    input  logic [7:0]           i_color,
    input  logic                 i_auto_newline,
    input  logic [15:0]          i_position,
    input  logic                 i_fifo_full,
    output logic                 o_push,
    output tccw_pkg::t_op_entry  o_entry
);

    localparam int unsigned RECIP   = (1 << 24) / SCREEN_WIDTH;
    localparam int unsigned RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned PROD_W  = 16 + RECIP_W;
    localparam int unsigned Q_W     = $clog2(65535 / SCREEN_WIDTH + 1);

    tccw_pkg::t_op_kind  kind_in;
    logic [PROD_W-1:0]   prod;
    logic                take;
    logic                adv;
    logic                is_nop;
    logic [15:0]         qw;
    logic [15:0]         rem;
    logic [15:0]         col_full;

    logic                r_valid;
    tccw_pkg::t_op_kind  r_kind;
    logic [7:0]          r_char_code;
    logic [7:0]          r_color;
    logic                r_auto_newline;
    logic [15:0]         r_position;
    logic [Q_W-1:0]      r_q;

    // Classify the incoming operation
    always_comb begin
        unique case (i_opcode)
            tccw_pkg::OPC_STR_CHAR: begin
                priority if (i_char_code == tccw_pkg::CH_NEWLINE) begin
                    kind_in = tccw_pkg::OPK_NEWLINE;
                end else if (i_char_code == tccw_pkg::CH_RETURN) begin
                    kind_in = tccw_pkg::OPK_RETURN;
                end else if (i_char_code == tccw_pkg::CH_TAB) begin
                    kind_in = tccw_pkg::OPK_TAB;
                end else begin
                    kind_in = tccw_pkg::OPK_CHAR;
                end
            end
            tccw_pkg::OPC_STR_END:  kind_in = tccw_pkg::OPK_END;
            tccw_pkg::OPC_PUT_CHAR: kind_in = tccw_pkg::OPK_PUT;
            tccw_pkg::OPC_BACK:     kind_in = tccw_pkg::OPK_BACK;
            tccw_pkg::OPC_SET_CUR:  kind_in = tccw_pkg::OPK_SET;
            default:                kind_in = tccw_pkg::OPK_NOP;
        endcase
    end

    // Estimate position / SCREEN_WIDTH by a reciprocal multiply
    assign prod = PROD_W'(i_position) * PROD_W'(RECIP);

    // Drop unused opcodes; otherwise advance when the queue has room
    assign is_nop  = (r_kind == tccw_pkg::OPK_NOP);
    assign adv     = r_valid & (is_nop | ~i_fifo_full);
    assign o_stall = r_valid & ~adv;
    assign take    = i_valid & ~o_stall;
    assign o_push  = adv & ~is_nop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind         <= kind_in;
            r_char_code    <= i_char_code;
            r_color        <= i_color;
            r_auto_newline <= i_auto_newline;
            r_position     <= i_position;
            r_q            <= prod[24 +: Q_W];
        end
    end

    // Remainder with one correction step; the estimate is low by at most one
    assign qw       = 16'(r_q * SCREEN_WIDTH);
    assign rem      = r_position - qw;
    assign col_full = (rem >= 16'(SCREEN_WIDTH)) ? rem - 16'(SCREEN_WIDTH) : rem;

    always_comb begin
        o_entry.kind         = r_kind;
        o_entry.char_code    = r_char_code;
        o_entry.color        = r_color;
        o_entry.auto_newline = r_auto_newline;
        o_entry.position     = r_position;
        o_entry.pos_col      = col_full[tccw_pkg::COL_BITS-1:0];
    end

endmodule

### hw/rtl/tccw_fifo.sv
// Short queue of classified operations between front and back.
// Depends on tccw_pkg.
module tccw_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tccw_pkg::t_op_entry  i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tccw_pkg::t_op_entry  o_data
);

    tccw_pkg::t_op_entry                r_mem [tccw_pkg::FIFO_DEPTH];
    logic [tccw_pkg::PTR_W-1:0]         r_wr_ptr;
    logic [tccw_pkg::PTR_W-1:0]         r_rd_ptr;
    logic [tccw_pkg::CNT_W-1:0]         r_count;

    assign o_full  = (r_count == tccw_pkg::CNT_W'(tccw_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/tccw_back.sv
// Back stage: carries out queued operations against the cursor and the running index,
// one result a cycle into an output register unless stalled. Depends on tccw_pkg.
module tccw_back #(
    parameter int unsigned SCREEN_WIDTH = 80,
    parameter int unsigned TEXT_ROWS    = 22,
    parameter int unsigned TAB_WIDTH    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_system_mode,
    input  logic                 i_empty,
    input  tccw_pkg::t_op_entry  i_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tccw_pkg::t_result    o_result
);

    localparam int unsigned LIM_NORM  = TEXT_ROWS * SCREEN_WIDTH + SCREEN_WIDTH - 1;
    localparam int unsigned LIM_MAX   = (LIM_NORM > tccw_pkg::SYS_LIMIT) ? LIM_NORM
                                                                         : tccw_pkg::SYS_LIMIT;
    localparam int unsigned CUR_W     = $clog2(LIM_MAX + 1);
    localparam int unsigned COL_W     = $clog2(SCREEN_WIDTH);
    localparam int unsigned STEP_W    = (TAB_WIDTH > 2) ? $clog2(TAB_WIDTH) : 1;
    localparam int unsigned WRAP_MOD  = 65536 % SCREEN_WIDTH;
    localparam logic [15:0] LIM_N16   = 16'(LIM_NORM);
    localparam logic [15:0] LIM_S16   = 16'(tccw_pkg::SYS_LIMIT);
    localparam logic [COL_W-1:0] LCOL_N = COL_W'(LIM_NORM % SCREEN_WIDTH);
    localparam logic [COL_W-1:0] LCOL_S = COL_W'(tccw_pkg::SYS_LIMIT % SCREEN_WIDTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [STEP_W-1:0] TAB_LAST = STEP_W'(TAB_WIDTH - 1);

    logic [15:0]        r_run;
    logic [COL_W-1:0]   r_rcol;
    logic [CUR_W-1:0]   r_cursor;
    logic [COL_W-1:0]   r_ccol;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    tccw_pkg::t_result  r_out;

    logic [15:0]        n_run;
    logic [COL_W-1:0]   n_rcol;
    logic [CUR_W-1:0]   n_cursor;
    logic [COL_W-1:0]   n_ccol;
    logic [STEP_W-1:0]  n_step;

    logic               out_free;
    logic               emit;
    tccw_pkg::t_result  res;
    logic [15:0]        cur16;
    logic [COL_W-1:0]   epos_col;

    // Running index arithmetic
    logic [16:0]        nl_sum;
    logic [15:0]        nl_run;
    logic [COL_W-1:0]   nl_col;
    logic [15:0]        inc_run;
    logic [COL_W-1:0]   inc_col;

    // Shared cursor clamp
    logic [15:0]        set_p;
    logic [COL_W-1:0]   set_pcol;
    logic [15:0]        lim;
    logic [COL_W-1:0]   lim_col;
    logic [CUR_W-1:0]   cl_cur;
    logic [COL_W-1:0]   cl_col;

    assign out_free = ~r_out_valid | ~i_stall;
    assign cur16    = 16'(r_cursor);
    assign epos_col = i_entry.pos_col[COL_W-1:0];

    // Newline: add one row, fixing the column when the index wraps
    assign nl_sum = {1'b0, r_run} + 17'(SCREEN_WIDTH);
    assign nl_run = nl_sum[15:0];
    always_comb begin
        if (!nl_sum[16]) begin
            nl_col = r_rcol;
        end else if (r_rcol >= COL_W'(WRAP_MOD)) begin
            nl_col = r_rcol - COL_W'(WRAP_MOD);
        end else begin
            nl_col = r_rcol + COL_W'(SCREEN_WIDTH - WRAP_MOD);
        end
    end

    // Step to the next cell; a wrap to zero lands on column zero
    assign inc_run = r_run + 16'd1;
    assign inc_col = ((r_run == 16'hFFFF) || (r_rcol == COL_LAST)) ? '0 : r_rcol + 1'b1;

    // Select the value to load into the cursor
    always_comb begin
        set_p    = '0;
        set_pcol = '0;
        unique case (i_entry.kind)
            tccw_pkg::OPK_END: begin
                if (i_entry.auto_newline) begin
                    set_p    = nl_run - 16'(nl_col);
                    set_pcol = '0;
                end else begin
                    set_p    = r_run;
                    set_pcol = r_rcol;
                end
            end
            tccw_pkg::OPK_PUT: begin
                set_p    = cur16 + 16'd1;
                set_pcol = (r_ccol == COL_LAST) ? '0 : r_ccol + 1'b1;
            end
            tccw_pkg::OPK_BACK: begin
                if (r_cursor == '0) begin
                    set_p    = '0;
                    set_pcol = '0;
                end else begin
                    set_p    = cur16 - 16'd1;
                    set_pcol = (r_ccol == '0) ? COL_LAST : r_ccol - 1'b1;
                end
            end
            tccw_pkg::OPK_SET: begin
                set_p    = i_entry.position;
                set_pcol = epos_col;
            end
            default: begin
                set_p    = '0;
                set_pcol = '0;
            end
        endcase
    end

    // Clamp against the limit of the current mode
    assign lim     = i_system_mode ? LIM_S16 : LIM_N16;
    assign lim_col = i_system_mode ? LCOL_S : LCOL_N;
    assign cl_cur  = (set_p > lim) ? CUR_W'(lim) : CUR_W'(set_p);
    assign cl_col  = (set_p > lim) ? lim_col : set_pcol;

    // Execute the head operation
    always_comb begin
        n_run    = r_run;
        n_rcol   = r_rcol;
        n_cursor = r_cursor;
        n_ccol   = r_ccol;
        n_step   = r_step;
        o_pop    = 1'b0;
        emit     = 1'b0;
        res      = '0;
        if (!i_empty) begin
            unique case (i_entry.kind)
                tccw_pkg::OPK_NEWLINE: begin
                    n_run  = nl_run;
                    n_rcol = nl_col;
                    o_pop  = 1'b1;
                end
                tccw_pkg::OPK_RETURN: begin
                    n_run  = r_run - 16'(r_rcol);
                    n_rcol = '0;
                    o_pop  = 1'b1;
                end
                tccw_pkg::OPK_CHAR: begin
                    if (out_free) begin
                        emit           = 1'b1;
                        res.kind       = tccw_pkg::RK_CELL;
                        res.cell_index = r_run;
                        res.char_out   = i_entry.char_code;
                        res.attr_out   = i_entry.color;
                        res.last       = 1'b1;
                        n_run          = inc_run;
                        n_rcol         = inc_col;
                        o_pop          = 1'b1;
                    end
                end
                tccw_pkg::OPK_TAB: begin
                    if (out_free) begin
                        emit           = 1'b1;
                        res.kind       = tccw_pkg::RK_CELL;
                        res.cell_index = r_run;
                        res.char_out   = tccw_pkg::CH_SPACE;
                        res.attr_out   = i_entry.color;
                        res.last       = (r_step == TAB_LAST);
                        n_run          = inc_run;
                        n_rcol         = inc_col;
                        if (r_step == TAB_LAST) begin
                            n_step = '0;
                            o_pop  = 1'b1;
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                    end
                end
                tccw_pkg::OPK_END, tccw_pkg::OPK_SET: begin
                    if (out_free) begin
                        emit           = 1'b1;
                        res.kind       = tccw_pkg::RK_CURSOR;
                        res.cell_index = 16'(cl_cur);
                        res.last       = 1'b1;
                        n_cursor       = cl_cur;
                        n_ccol         = cl_col;
                        n_run          = 16'(cl_cur);
                        n_rcol         = cl_col;
                        o_pop          = 1'b1;
                    end
                end
                tccw_pkg::OPK_PUT: begin
                    if (out_free) begin
                        emit = 1'b1;
                        if (r_step == '0) begin
                            res.kind       = tccw_pkg::RK_CELL;
                            res.cell_index = cur16;
                            res.char_out   = i_entry.char_code;
                            res.attr_out   = i_entry.color;
                            n_step         = STEP_W'(1);
                        end else begin
                            res.kind       = tccw_pkg::RK_CURSOR;
                            res.cell_index = 16'(cl_cur);
                            res.last       = 1'b1;
                            n_cursor       = cl_cur;
                            n_ccol         = cl_col;
                            n_run          = 16'(cl_cur);
                            n_rcol         = cl_col;
                            n_step         = '0;
                            o_pop          = 1'b1;
                        end
                    end
                end
                tccw_pkg::OPK_BACK: begin
                    if (out_free) begin
                        emit = 1'b1;
                        if (r_step == '0) begin
                            res.kind       = tccw_pkg::RK_CURSOR;
                            res.cell_index = 16'(cl_cur);
                            n_cursor       = cl_cur;
                            n_ccol         = cl_col;
                            n_run          = 16'(cl_cur);
                            n_rcol         = cl_col;
                            n_step         = STEP_W'(1);
                        end else begin
                            res.kind       = tccw_pkg::RK_CELL;
                            res.cell_index = cur16;
                            res.char_out   = tccw_pkg::CH_SPACE;
                            res.attr_out   = i_entry.color;
                            res.last       = 1'b1;
                            n_step         = '0;
                            o_pop          = 1'b1;
                        end
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
        res.in_screen = (res.cell_index < 16'(tccw_pkg::SCREEN_CELLS));
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_rcol      <= '0;
            r_cursor    <= '0;
            r_ccol      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_run    <= n_run;
            r_rcol   <= n_rcol;
            r_cursor <= n_cursor;
            r_ccol   <= n_ccol;
            r_step   <= n_step;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### hw/rtl/text_console_cell_writer.sv
// Top level of the text console cell writer: front, queue, back and the
// mode register behind an APB-style port. Depends on tccw_pkg and the tccw modules.
//
// Turns console operations into cell writes and cursor updates. String
// characters, string end and set cursor each give one result, newline and
// return none, put char and backspace two, and a tab TAB_WIDTH results. The
// back stage issues one result per cycle into its output register while the
// output is not stalled and sets the rate; unused opcodes drop in the front.
// An accepted transaction reaches the back after the front register and a
// four-entry queue, so the block holds up to five transactions, the one the
// back is working on included, while a tab runs or the output is stalled.
// No clearing pass after reset.
module text_console_cell_writer #(
    parameter int unsigned SCREEN_WIDTH = 80,
    parameter int unsigned TEXT_ROWS    = 22,
    parameter int unsigned TAB_WIDTH    = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color,
    input  logic        i_auto_newline,
    input  logic [15:0] i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [15:0] o_cell_index,
    output logic [7:0]  o_char_out,
    output logic [7:0]  o_attr_out,
    output logic        o_in_screen,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 r_system_mode;
    logic                 push;
    logic                 pop;
    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 reg_hit;
    tccw_pkg::t_op_entry  fe_entry;
    tccw_pkg::t_op_entry  head_entry;
    tccw_pkg::t_result    result;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(tccw_pkg::REG_SYSTEM_MODE));
    assign prdata  = reg_hit ? {31'b0, r_system_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_system_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_system_mode <= pwdata[0];
        end
    end

    tccw_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_char_code    (i_char_code),
        .i_color        (i_color),
        .i_auto_newline (i_auto_newline),
        .i_position     (i_position),
        .i_fifo_full    (fifo_full),
        .o_push         (push),
        .o_entry        (fe_entry)
    );

    tccw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fe_entry),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_empty (fifo_empty),
        .o_data  (head_entry)
    );

    tccw_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .TEXT_ROWS    (TEXT_ROWS),
        .TAB_WIDTH    (TAB_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_system_mode (r_system_mode),
        .i_empty       (fifo_empty),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (result)
    );

    // Drive the result ports
    assign o_kind       = result.kind;
    assign o_cell_index = result.cell_index;
    assign o_char_out   = result.char_out;
    assign o_attr_out   = result.attr_out;
    assign o_in_screen  = result.in_screen;
    assign o_last       = result.last;

endmodule
